// File: rtl/tlsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tlsm_pkg;

    // Default configuration
    localparam int LIST_DEPTH_DEF  = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed widths of the port fields
    localparam int FIELD_WIDTH  = 32;
    localparam int OPCODE_WIDTH = 2;

    // Input opcodes
    localparam logic [OPCODE_WIDTH-1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [OPCODE_WIDTH-1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [OPCODE_WIDTH-1:0] OP_MERGE         = 2'd2;

    // Command kinds held in the queue between front and back
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_FIRST  = 2'd0;
    localparam t_kind KIND_SECOND = 2'd1;
    localparam t_kind KIND_MERGE  = 2'd2;

    // Head of the command queue as seen by the back end
    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_q_head;

endpackage
`default_nettype wire

// File: rtl/tlsm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tlsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/tlsm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tlsm_front #(
    parameter int VALUE_WIDTH = tlsm_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire logic [tlsm_pkg::OPCODE_WIDTH-1:0]  i_opcode,
    input  wire logic [tlsm_pkg::FIELD_WIDTH-1:0]   i_element,
    output logic                                    o_stall,
    output tlsm_pkg::t_q_head                       o_head,
    output logic      [VALUE_WIDTH-1:0]             o_head_value,
    input  wire logic                               i_pop
);
    import tlsm_pkg::*;

    localparam int Q_DEPTH = 2;

    t_kind                  r_kind [Q_DEPTH];
    logic [VALUE_WIDTH-1:0] r_val  [Q_DEPTH];
    logic                   r_wr_ptr;
    logic                   r_rd_ptr;
    logic [1:0]             r_cnt;

    t_kind                  cls_kind;
    logic                   cls_keep;
    logic                   push;
    logic [VALUE_WIDTH-1:0] in_val;

    // Element narrowed or zero-extended to the value width
    generate
        if (VALUE_WIDTH <= FIELD_WIDTH) begin : g_narrow
            assign in_val = i_element[VALUE_WIDTH-1:0];
        end else begin : g_wide
            assign in_val = {{(VALUE_WIDTH - FIELD_WIDTH){1'b0}}, i_element};
        end
    endgenerate

    // Classify the opcode; the unused code is taken and discarded
    always_comb begin
        cls_kind = KIND_MERGE;
        cls_keep = 1'b1;
        unique case (i_opcode)
            OP_APPEND_FIRST:  cls_kind = KIND_FIRST;
            OP_APPEND_SECOND: cls_kind = KIND_SECOND;
            OP_MERGE:         cls_kind = KIND_MERGE;
            default:          cls_keep = 1'b0;
        endcase
    end

    assign o_stall = (r_cnt == 2'(Q_DEPTH));
    assign push    = i_valid && !o_stall && cls_keep;

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    // Queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_kind[r_wr_ptr] <= cls_kind;
            r_val[r_wr_ptr]  <= in_val;
        end
    end

    assign o_head       = '{valid: (r_cnt != 2'd0), kind: r_kind[r_rd_ptr]};
    assign o_head_value = r_val[r_rd_ptr];

endmodule
`default_nettype wire

// File: rtl/tlsm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tlsm_back #(
    parameter int LIST_DEPTH  = tlsm_pkg::LIST_DEPTH_DEF,
    parameter int VALUE_WIDTH = tlsm_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire tlsm_pkg::t_q_head                 i_head,
    input  wire logic [VALUE_WIDTH-1:0]            i_head_value,
    output logic                                   o_pop,
    input  wire logic                              i_stall,
    output logic                                   o_valid,
    output logic      [tlsm_pkg::FIELD_WIDTH-1:0]  o_merged_value,
    output logic                                   o_last_of_run,
    output logic                                   o_overflow_seen
);
    import tlsm_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                   r_state, n_state;
    logic [CW-1:0]          r_c1, n_c1;
    logic [CW-1:0]          r_c2, n_c2;
    logic [CW-1:0]          r_i, n_i;
    logic [CW-1:0]          r_j, n_j;
    logic                   r_dropped, n_dropped;
    logic                   r_out_valid, n_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_val, n_out_val;
    logic                   r_out_last, n_out_last;
    logic                   r_out_ovf, n_out_ovf;

    logic                   we1, we2;
    logic [VALUE_WIDTH-1:0] rd1, rd2;
    logic                   have1, have2, take1, is_last, can_out, emit_fire;
    logic [CW:0]            done_n, total;
    logic                   room1, room2;

    // List storage; the read address is the next index so data lines up with r_i/r_j
    tlsm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(LIST_DEPTH)) u_ram_first (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (r_c1[AW-1:0]),
        .i_wdata (i_head_value),
        .i_raddr (n_i[AW-1:0]),
        .o_rdata (rd1)
    );

    tlsm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(LIST_DEPTH)) u_ram_second (
        .i_clk   (i_clk),
        .i_we    (we2),
        .i_waddr (r_c2[AW-1:0]),
        .i_wdata (i_head_value),
        .i_raddr (n_j[AW-1:0]),
        .o_rdata (rd2)
    );

    assign room1 = (r_c1 < CW'(LIST_DEPTH));
    assign room2 = (r_c2 < CW'(LIST_DEPTH));
    assign o_pop = i_head.valid && (r_state == ST_IDLE);
    assign we1   = o_pop && (i_head.kind == KIND_FIRST) && room1;
    assign we2   = o_pop && (i_head.kind == KIND_SECOND) && room2;

    // Merge selection: first head wins only when strictly less
    assign have1     = (r_i < r_c1);
    assign have2     = (r_j < r_c2);
    assign take1     = have1 && (!have2 || ($signed(rd1) < $signed(rd2)));
    assign done_n    = {1'b0, r_i} + {1'b0, r_j} + (CW + 1)'(1);
    assign total     = {1'b0, r_c1} + {1'b0, r_c2};
    assign is_last   = (done_n == total);
    assign can_out   = !r_out_valid || !i_stall;
    assign emit_fire = (r_state == ST_EMIT) && can_out;

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_c1        = r_c1;
        n_c2        = r_c2;
        n_i         = r_i;
        n_j         = r_j;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid && i_stall;
        n_out_val   = r_out_val;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;

        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    unique case (i_head.kind)
                        KIND_FIRST: begin
                            if (room1) begin
                                n_c1 = r_c1 + CW'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        KIND_SECOND: begin
                            if (room2) begin
                                n_c2 = r_c2 + CW'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        default: begin
                            // Merge of two empty lists only clears the flag
                            n_i = '0;
                            n_j = '0;
                            if (r_c1 == '0 && r_c2 == '0) begin
                                n_dropped = 1'b0;
                            end else begin
                                n_state = ST_EMIT;
                            end
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (can_out) begin
                    n_out_valid = 1'b1;
                    n_out_val   = take1 ? rd1 : rd2;
                    n_out_last  = is_last;
                    n_out_ovf   = r_dropped;
                    if (take1) begin
                        n_i = r_i + CW'(1);
                    end else begin
                        n_j = r_j + CW'(1);
                    end
                    if (is_last) begin
                        n_state   = ST_IDLE;
                        n_i       = '0;
                        n_j       = '0;
                        n_c1      = '0;
                        n_c2      = '0;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_c1        <= '0;
            r_c2        <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_c1        <= n_c1;
            r_c2        <= n_c2;
            r_i         <= n_i;
            r_j         <= n_j;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_out_val  <= n_out_val;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_valid         = r_out_valid;
    assign o_last_of_run   = r_out_last;
    assign o_overflow_seen = r_out_ovf;

    generate
        if (VALUE_WIDTH >= FIELD_WIDTH) begin : g_out_narrow
            assign o_merged_value = r_out_val[FIELD_WIDTH-1:0];
        end else begin : g_out_wide
            assign o_merged_value = {{(FIELD_WIDTH - VALUE_WIDTH){1'b0}}, r_out_val};
        end
    endgenerate

`ifndef ASSERT_OFF
    a_emit_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (have1 || have2))
        else $error("merge running with both lists exhausted");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c1 <= CW'(LIST_DEPTH)) && (r_c2 <= CW'(LIST_DEPTH)))
        else $error("list count beyond depth");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_fire && is_last) |=> (r_c1 == '0 && r_c2 == '0 && !r_dropped))
        else $error("lists not emptied after final transfer");

    a_no_pop_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> !o_pop)
        else $error("command popped during merge");
`endif

endmodule
`default_nettype wire

// File: rtl/two_list_sorted_merge.sv
// Two-list sorted merge.
// Input channel (i_valid / o_stall, i_opcode, i_element): opcode 0 appends the
// element to the first list, 1 to the second, 2 merges; code 3 is taken and
// ignored. Output channel (o_valid / i_stall): one transfer per merged element,
// o_last_of_run on the final one, o_overflow_seen set on all of them if an
// append was dropped on a full list since the previous merge.
// Throughput: one append per cycle while the queue has room. A merge of N + M
// elements passes a start state, then streams one element per cycle while the
// output is not stalled, read from the single registered read port of each list
// memory. Commands pass through a two-entry queue, so the input keeps taking
// items while the back end works until the queue fills. With the back end idle,
// a merge passes the queue, the start state with its read and the output register.
// A stalled output holds its element; the merge pauses and the queue fills.
// Reset (synchronous, active low) empties both lists, the queue and the drop
// flag and needs no clearing pass; list memory contents are never read unwritten.
`timescale 1ns / 1ps
`default_nettype none
module two_list_sorted_merge #(
    parameter int LIST_DEPTH  = tlsm_pkg::LIST_DEPTH_DEF,
    parameter int VALUE_WIDTH = tlsm_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [tlsm_pkg::OPCODE_WIDTH-1:0] i_opcode,
    input  wire logic [tlsm_pkg::FIELD_WIDTH-1:0]  i_element,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic      [tlsm_pkg::FIELD_WIDTH-1:0]  o_merged_value,
    output logic                                   o_last_of_run,
    output logic                                   o_overflow_seen
);
    import tlsm_pkg::*;

    t_q_head                head;
    logic [VALUE_WIDTH-1:0] head_value;
    logic                   pop;

    // Front end: accept, classify, queue
    tlsm_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_opcode     (i_opcode),
        .i_element    (i_element),
        .o_stall      (o_stall),
        .o_head       (head),
        .o_head_value (head_value),
        .i_pop        (pop)
    );

    // Back end: list storage and merge engine
    tlsm_back #(.LIST_DEPTH(LIST_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_head_value    (head_value),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_merged_value  (o_merged_value),
        .o_last_of_run   (o_last_of_run),
        .o_overflow_seen (o_overflow_seen)
    );

endmodule
`default_nettype wire
